### rtl/core/assert_macros.svh
// Assertion macros used by the page extent allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/pea_pkg.sv
// Types and constants of the page extent allocator.
package pea_pkg;

	localparam int PAGE_W = 40;

	// command codes
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_ALLOC1 = 2'd1;
	localparam logic [1:0] CMD_ALLOCN = 2'd2;
	localparam logic [1:0] CMD_FREE   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef logic [PAGE_W-1:0] page_t;

	typedef struct packed {
		page_t base;
		page_t count;
	} extent_t;

endpackage

### rtl/core/page_extent_allocator.sv
// Page extent allocator: free-extent stack kept in one synchronous memory.
//
// A command transfer is taken when start is high and busy is low; exactly one
// result comes back per command, on alloc_page/status with done high for one
// cycle, and the receiver cannot hold it off. Allocate-one pops entries from
// the top of stack (empty extents on top are discarded) until it finds pages
// or the table runs empty; allocate-n and free examine the entries from the
// bottom until one matches or every live entry has been examined. The scan
// is paced by the single read port of the extent memory: one entry is read
// per cycle and checked the cycle after, while the next read is already out.
// A command can be accepted in the same cycle that done is high. After reset
// the table is empty and ready at once; unwritten entries are never read,
// since only entries below the top of stack are examined. Allocate-n picks
// the first extent from the bottom that holds enough pages and carves from
// its base; free merges into the first bordering extent, checking the one
// just above the page before the one just below, else pushes a one-page
// extent. Page arithmetic wraps at 40 bits. Status: 0 ok, 1 empty or no fit,
// 2 table full.
`include "assert_macros.svh"

module page_extent_allocator
	import pea_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [PAGE_W-1:0] page,
	input  logic [PAGE_W-1:0] count,
	output logic              done,
	output logic [PAGE_W-1:0] alloc_page,
	output logic [1:0]        status
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PTR_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(TABLE_DEPTH);
	localparam logic [PTR_W-1:0] ONE_P   = PTR_W'(1);
	localparam page_t PAGE_ONE = PAGE_W'(1);

	// controller states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_ADD     = 3'd1;
	localparam logic [2:0] S_POP_RD  = 3'd2;
	localparam logic [2:0] S_POP_CHK = 3'd3;
	localparam logic [2:0] S_SCAN    = 3'd4;

	// extent memory, one read and one write port, registered read data
	extent_t mem [TABLE_DEPTH];
	extent_t rd_q;

	logic [2:0]       state_q;
	logic [PTR_W-1:0] top_q;      // number of live entries
	logic [1:0]       cmd_q;
	page_t            page_q;
	page_t            page_inc_q; // page + 1, for the merge-above test
	page_t            cnt_q;

	// scan pipeline: issue index, then the index whose data is in rd_q
	logic [PTR_W-1:0] rd_idx_q;
	logic             chk_vld_q;
	logic [IDX_W-1:0] chk_idx_q;

	logic             done_q;
	page_t            alloc_page_q;
	logic [1:0]       status_q;

	// memory port controls
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	extent_t          mem_wdata;

	logic             accept;
	logic             is_alloc;
	logic             top_free;
	logic             fit;
	logic             merge_up;   // freed page sits just below the extent base
	logic             merge_dn;   // freed page sits just past the extent end
	logic             hit;
	logic             scan_rd;
	logic             scan_end;
	page_t            cnt_dec;
	logic [PTR_W-1:0] top_dec;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign done       = done_q;
	assign alloc_page = alloc_page_q;
	assign status     = status_q;

	assign is_alloc = (cmd_q == CMD_ALLOCN);
	assign top_free = (top_q < DEPTH_P);
	assign top_dec  = top_q - ONE_P;
	assign cnt_dec  = rd_q.count - PAGE_ONE;

	assign fit      = (rd_q.count >= cnt_q);
	assign merge_up = (page_inc_q == rd_q.base);
	assign merge_dn = ((rd_q.base + rd_q.count) == page_q);
	assign hit      = chk_vld_q && (is_alloc ? fit : (merge_up || merge_dn));
	assign scan_rd  = (rd_idx_q < top_q) && !hit;
	assign scan_end = !chk_vld_q && (rd_idx_q == top_q);

	// read port: top entry for pops, running index for scans
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = top_dec[IDX_W-1:0];
		case (state_q)
			S_POP_RD: begin
				mem_re = (top_q != '0);
			end
			S_SCAN: begin
				mem_re    = scan_rd;
				mem_raddr = rd_idx_q[IDX_W-1:0];
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// write port: push at top, or modify the entry that matched
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = top_q[IDX_W-1:0];
		mem_wdata = '{base: page_q, count: cnt_q};
		case (state_q)
			S_ADD: begin
				mem_we = top_free;
			end
			S_POP_CHK: begin
				// remainder goes back only if pages are left
				mem_we    = (rd_q.count != '0) && (cnt_dec != '0);
				mem_wdata = '{base: rd_q.base + PAGE_ONE, count: cnt_dec};
			end
			S_SCAN: begin
				if (hit) begin
					mem_we    = 1'b1;
					mem_waddr = chk_idx_q;
					if (is_alloc) begin
						mem_wdata = '{base: rd_q.base + cnt_q, count: rd_q.count - cnt_q};
					end else if (merge_up) begin
						mem_wdata = '{base: rd_q.base - PAGE_ONE, count: rd_q.count + PAGE_ONE};
					end else begin
						mem_wdata = '{base: rd_q.base, count: rd_q.count + PAGE_ONE};
					end
				end else if (scan_end && !is_alloc) begin
					mem_we    = top_free;
					mem_wdata = '{base: page_q, count: PAGE_ONE};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// command latch
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd;
			page_q     <= page;
			page_inc_q <= page + PAGE_ONE;
			cnt_q      <= count;
		end
	end

	// result payload; only looked at while done is high
	always_ff @(posedge clk) begin
		alloc_page_q <= '0;
		status_q     <= ST_OK;
		case (state_q)
			S_ADD: begin
				status_q <= top_free ? ST_OK : ST_FULL;
			end
			S_POP_RD: begin
				if (top_q == '0) begin
					status_q <= ST_EMPTY;
				end
			end
			S_POP_CHK: begin
				alloc_page_q <= rd_q.base;
			end
			S_SCAN: begin
				if (hit) begin
					alloc_page_q <= is_alloc ? rd_q.base : '0;
				end else if (is_alloc) begin
					status_q <= ST_EMPTY;
				end else begin
					status_q <= top_free ? ST_OK : ST_FULL;
				end
			end
			default: begin
				status_q <= ST_OK;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			top_q     <= '0;
			rd_idx_q  <= '0;
			chk_vld_q <= 1'b0;
			chk_idx_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					rd_idx_q  <= '0;
					chk_vld_q <= 1'b0;
					if (accept) begin
						case (cmd)
							CMD_ADD:    state_q <= S_ADD;
							CMD_ALLOC1: state_q <= S_POP_RD;
							default:    state_q <= S_SCAN;
						endcase
					end
				end
				S_ADD: begin
					if (top_free) begin
						top_q <= top_q + ONE_P;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_POP_RD: begin
					if (top_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						top_q   <= top_dec;
						state_q <= S_POP_CHK;
					end
				end
				S_POP_CHK: begin
					if (rd_q.count == '0) begin
						// empty extent discarded, keep popping
						state_q <= S_POP_RD;
					end else begin
						if (cnt_dec != '0) begin
							top_q <= top_q + ONE_P;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					chk_vld_q <= scan_rd;
					chk_idx_q <= rd_idx_q[IDX_W-1:0];
					if (scan_rd) begin
						rd_idx_q <= rd_idx_q + ONE_P;
					end
					if (hit) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (scan_end) begin
						if (!is_alloc && top_free) begin
							top_q <= top_q + ONE_P;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`ASSERT_IMPLY(a_top_in_range, clk, arst_n, 1'b1, top_q <= DEPTH_P)
	`ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, accept, busy)
	`ASSERT_IMPLY(a_done_when_idle, clk, arst_n, done_q, state_q == S_IDLE)
	`ASSERT_IMPLY(a_full_means_full, clk, arst_n, done_q && (status_q == ST_FULL), top_q == DEPTH_P)
	`ASSERT_IMPLY(a_scan_write_on_hit, clk, arst_n, mem_we && (state_q == S_SCAN) && !scan_end, hit)

endmodule
